FILE: rtl/bfu_pkg.sv
// Package for the boid flock update block: sizes, register codes, state
// record type and the fixed-point helper functions.
// Used by the state memory, neighbour list, top level and testbench; depends on nothing.
`default_nettype none

package bfu_pkg;

  localparam int BOID_COUNT     = 256;
  localparam int NEIGHBOR_COUNT = 4;
  localparam int FRACTION_BITS  = 20;

  localparam int ADDR_W  = $clog2(BOID_COUNT);
  localparam int NCNT_W  = $clog2(NEIGHBOR_COUNT + 1);
  localparam int NSEL_W  = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;
  // floor(log2(NEIGHBOR_COUNT))
  localparam int GROUP_SHIFT = $clog2(NEIGHBOR_COUNT + 1) - 1;

  localparam logic [31:0] RESET_MARGIN = 32'd33554432;
  localparam logic [31:0] START_VEL    = 32'd10485760;
  localparam logic [31:0] LOW_BOUND    = 32'd33554432;

  // configuration register indexes
  localparam logic [2:0] CFG_COHESION_SHIFT   = 3'd0;
  localparam logic [2:0] CFG_SEPARATION_SHIFT = 3'd1;
  localparam logic [2:0] CFG_ALIGNMENT_SHIFT  = 3'd2;
  localparam logic [2:0] CFG_SPEED_LOG_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_REPEL_RADIUS     = 3'd4;
  localparam logic [2:0] CFG_EDGE_PUSH_STEP   = 3'd5;
  localparam logic [2:0] CFG_RIGHT_LIMIT      = 3'd6;
  localparam logic [2:0] CFG_BOTTOM_LIMIT     = 3'd7;

  typedef struct packed {
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic [31:0] x_vel;
    logic [31:0] y_vel;
  } boid_state_t;

  // arithmetic right shift, amounts above 31 keep only the sign
  function automatic logic [31:0] sar32(input logic [31:0] v, input logic [5:0] s);
    logic [5:0] sc;
    sc = (s > 6'd31) ? 6'd31 : s;
    return 32'($signed(v) >>> sc);
  endfunction

  function automatic logic [31:0] wrap_abs(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [11:0] pixel12(input logic [31:0] p);
    logic [31:0] t;
    t = 32'($signed(p) >>> FRACTION_BITS);
    return t[11:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bfu_if.sv
// Channel interfaces of the boid flock update block: step items in,
// pixel results out, each with a valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface bfu_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         boid_sel;
  logic signed [31:0] load_x_pos;
  logic signed [31:0] load_y_pos;
  logic signed [31:0] load_x_vel;
  logic signed [31:0] load_y_vel;

  modport source (output valid, func, boid_sel, load_x_pos, load_y_pos,
                  load_x_vel, load_y_vel, input ready);
  modport sink   (input valid, func, boid_sel, load_x_pos, load_y_pos,
                  load_x_vel, load_y_vel, output ready);
endinterface

interface bfu_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] pixel_x;
  logic signed [11:0] pixel_y;
  logic [7:0]         out_index;

  modport source (output valid, pixel_x, pixel_y, out_index, input ready);
  modport sink   (input valid, pixel_x, pixel_y, out_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/bfu_state_mem.sv
// Boid state memory: one record per boid, one write and one registered read
// a cycle. Per-entry valid bits stand in for the reset contents.
// Depends on bfu_pkg.
`default_nettype none

module bfu_state_mem (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire [bfu_pkg::ADDR_W-1:0]  rd_addr_i,
  input  wire                        wr_en_i,
  input  wire [bfu_pkg::ADDR_W-1:0]  wr_addr_i,
  input  bfu_pkg::boid_state_t       wr_data_i,
  output bfu_pkg::boid_state_t       rd_data_o
);

  bfu_pkg::boid_state_t             mem [bfu_pkg::BOID_COUNT];
  bfu_pkg::boid_state_t             rd_q;
  logic [bfu_pkg::BOID_COUNT-1:0]   valid_q;
  logic                             rd_valid_q;
  logic [bfu_pkg::ADDR_W-1:0]       rd_addr_q;
  logic [31:0]                      addr_ext;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q      <= mem[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // an entry never written reads as its reset record
  assign addr_ext = 32'(rd_addr_q);

  always_comb begin
    if (rd_valid_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o.x_pos = bfu_pkg::RESET_MARGIN + addr_ext;
      rd_data_o.y_pos = bfu_pkg::RESET_MARGIN + (addr_ext << 3);
      rd_data_o.x_vel = bfu_pkg::START_VEL;
      rd_data_o.y_vel = bfu_pkg::START_VEL;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bfu_nbr_list.sv
// Sorted list of the nearest boids found so far; takes one candidate a
// cycle, later equal distances fall behind earlier ones.
// Depends on bfu_pkg.
`default_nettype none

module bfu_nbr_list (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                clear_i,
  input  wire                                ins_i,
  input  wire [31:0]                         dist_i,
  input  wire [bfu_pkg::ADDR_W-1:0]          idx_i,
  output logic [bfu_pkg::ADDR_W-1:0]         nb_idx_o  [bfu_pkg::NEIGHBOR_COUNT],
  output logic [31:0]                        nb_dist_o [bfu_pkg::NEIGHBOR_COUNT],
  output logic [bfu_pkg::NEIGHBOR_COUNT-1:0] nb_valid_o
);

  localparam int N = bfu_pkg::NEIGHBOR_COUNT;

  logic [bfu_pkg::ADDR_W-1:0] idx_q  [N];
  logic [31:0]                dist_q [N];
  logic [N-1:0]               valid_q;
  logic [N-1:0]               lt;
  logic [N-1:0]               take_new;
  logic [N-1:0]               take_prev;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      lt[k] = valid_q[k] && ($signed(dist_i) < $signed(dist_q[k]));
    end
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        take_prev[k] = 1'b0;
        take_new[k]  = lt[k] || !valid_q[k];
      end else begin
        take_prev[k] = lt[k-1];
        take_new[k]  = (lt[k] || !valid_q[k]) && valid_q[k-1] && !lt[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      for (int k = 0; k < N; k++) begin
        if (take_new[k]) begin
          idx_q[k]  <= idx_i;
          dist_q[k] <= dist_i;
        end else if (take_prev[k] && k > 0) begin
          idx_q[k]  <= idx_q[k-1];
          dist_q[k] <= dist_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (ins_i) begin
      valid_q <= valid_q | take_new | take_prev;
    end
  end

  assign nb_idx_o   = idx_q;
  assign nb_dist_o  = dist_q;
  assign nb_valid_o = valid_q;

endmodule

`default_nettype wire

FILE: rtl/boid_flock_update.sv
// Boid flock update, top level: step sequencer, shared datapath, config
// registers and output register.
// Depends on bfu_pkg, bfu_if, bfu_state_mem and bfu_nbr_list.
//
//   channel  dir  handshake     payload
//   in_s     in   valid/ready   func, boid_sel, load_x_pos/y_pos/x_vel/y_vel
//   out_s    out  valid/ready   pixel_x, pixel_y, out_index
//   cfg      in   cfg_we_i      cfg_addr_i, cfg_wdata_i (write only)
//
// A load or an out-of-range index goes from its transfer straight to the
// done state, from where its result moves to the output register and
// raises the result valid. An update first passes the self read and the
// scan, one state memory read per boid, the neighbour reads, four combine
// steps, one speed step, the bit-serial log2 (one bit a cycle) and four
// finishing steps. A stalled output holds the next result in the done state.
// Reset restores the boid table through per-entry valid bits, no sweep.
// The input is ready only while idle; a stalled result holds in the output
// register while the next item is taken in.
`default_nettype none

module boid_flock_update (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [2:0]  cfg_addr_i,
  input  wire [30:0] cfg_wdata_i,
  bfu_in_if.sink     in_s,
  bfu_out_if.source  out_s
);

  localparam int AW = bfu_pkg::ADDR_W;
  localparam int N  = bfu_pkg::NEIGHBOR_COUNT;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SELF  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_NBR   = 4'd3;
  localparam logic [3:0] S_COMB  = 4'd4;
  localparam logic [3:0] S_SPEED = 4'd5;
  localparam logic [3:0] S_LOG   = 4'd6;
  localparam logic [3:0] S_LIMIT = 4'd7;
  localparam logic [3:0] S_EDGE  = 4'd8;
  localparam logic [3:0] S_WB    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  // configuration registers
  logic [4:0]  coh_shift_q, sep_shift_q, ali_shift_q;
  logic [5:0]  speed_lim_q;
  logic [30:0] repel_q, push_q, right_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coh_shift_q <= 5'd6;
      sep_shift_q <= 5'd4;
      ali_shift_q <= 5'd2;
      speed_lim_q <= 6'd22;
      repel_q     <= 31'd10485760;
      push_q      <= 31'd1048576;
      right_q     <= 31'd637534208;
      bottom_q    <= 31'd469762048;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bfu_pkg::CFG_COHESION_SHIFT:   coh_shift_q <= cfg_wdata_i[4:0];
        bfu_pkg::CFG_SEPARATION_SHIFT: sep_shift_q <= cfg_wdata_i[4:0];
        bfu_pkg::CFG_ALIGNMENT_SHIFT:  ali_shift_q <= cfg_wdata_i[4:0];
        bfu_pkg::CFG_SPEED_LOG_LIMIT:  speed_lim_q <= cfg_wdata_i[5:0];
        bfu_pkg::CFG_REPEL_RADIUS:     repel_q     <= cfg_wdata_i;
        bfu_pkg::CFG_EDGE_PUSH_STEP:   push_q      <= cfg_wdata_i;
        bfu_pkg::CFG_RIGHT_LIMIT:      right_q     <= cfg_wdata_i;
        bfu_pkg::CFG_BOTTOM_LIMIT:     bottom_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [3:0]        state_q;
  logic [AW:0]       scan_q;
  logic [bfu_pkg::NCNT_W-1:0] kc_q;
  logic [1:0]        step_q;
  logic              out_valid_q;

  // datapath registers
  logic [AW-1:0]     b_q;
  logic [7:0]        idx_q;
  logic [31:0]       xp_q, yp_q;
  logic [31:0]       cx_q, cy_q, rx_q, ry_q, mx_q, my_q;
  logic [31:0]       tx_q, ty_q, vx_q, vy_q;
  logic [32:0]       speed_q;
  logic [5:0]        mag_q;
  logic [11:0]       res_x_q, res_y_q;
  logic [11:0]       out_x_q, out_y_q;
  logic [7:0]        out_idx_q;

  // memory and neighbour list connections
  logic                  in_xfer;
  logic                  in_range;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  bfu_pkg::boid_state_t  wr_data;
  bfu_pkg::boid_state_t  rd_data;
  logic                  nl_clear, nl_ins;
  logic [31:0]           cand_dist;
  logic [AW-1:0]         cand_idx;
  logic [AW-1:0]         nb_idx  [N];
  logic [31:0]           nb_dist [N];
  logic [N-1:0]          nb_valid;
  logic [bfu_pkg::NCNT_W-1:0] kc_prev;
  logic [bfu_pkg::NSEL_W-1:0] ksel, kissue;
  logic                  acc_en;
  logic                  slot_free;
  logic [31:0]           new_x, new_y;
  logic [5:0]            lim_shift;

  assign in_xfer   = in_s.valid && in_s.ready;
  assign in_range  = ({24'd0, in_s.boid_sel} < 32'(bfu_pkg::BOID_COUNT));
  assign in_s.ready = (state_q == S_IDLE);
  assign slot_free = !out_valid_q || out_s.ready;

  assign kc_prev  = kc_q - 1'b1;
  assign ksel     = kc_prev[bfu_pkg::NSEL_W-1:0];
  assign kissue   = kc_q[bfu_pkg::NSEL_W-1:0];
  assign acc_en   = (state_q == S_NBR) && (kc_q != '0) && nb_valid[ksel];

  // Manhattan distance of the boid just read from the updated one
  assign cand_dist = bfu_pkg::wrap_abs(xp_q - rd_data.x_pos)
                   + bfu_pkg::wrap_abs(yp_q - rd_data.y_pos);
  assign cand_idx  = kc_prev[0] ? AW'(0) : AW'(0);
  assign nl_clear  = (state_q == S_SELF);
  assign nl_ins    = (state_q == S_SCAN);

  assign new_x = xp_q + vx_q;
  assign new_y = yp_q + vy_q;
  assign lim_shift = mag_q - speed_lim_q;

  // read address: self at transfer, boid by boid in the scan, then neighbours
  always_comb begin
    rd_addr = b_q;
    case (state_q)
      S_IDLE: rd_addr = AW'(in_s.boid_sel);
      S_SELF: rd_addr = '0;
      S_SCAN: rd_addr = scan_q[AW-1:0];
      S_NBR:  rd_addr = nb_idx[kissue];
      default: rd_addr = b_q;
    endcase
  end

  // write: a load at transfer, or the updated record at write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = b_q;
    wr_data = '{x_pos: new_x, y_pos: new_y, x_vel: vx_q, y_vel: vy_q};
    if (state_q == S_IDLE) begin
      wr_en   = in_xfer && in_range && in_s.func;
      wr_addr = AW'(in_s.boid_sel);
      wr_data = '{x_pos: in_s.load_x_pos, y_pos: in_s.load_y_pos,
                  x_vel: in_s.load_x_vel, y_vel: in_s.load_y_vel};
    end else if (state_q == S_WB) begin
      wr_en = 1'b1;
    end
  end

  bfu_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // the boid now on the read port is the one addressed last cycle
  logic [AW:0] scan_prev;
  assign scan_prev = scan_q - 1'b1;

  bfu_nbr_list u_nbr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (nl_clear),
    .ins_i      (nl_ins),
    .dist_i     (cand_dist),
    .idx_i      (scan_prev[AW-1:0] | cand_idx),
    .nb_idx_o   (nb_idx),
    .nb_dist_o  (nb_dist),
    .nb_valid_o (nb_valid)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      kc_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // raise valid when a result moves in, drop it once transferred
      if (state_q == S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_s.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= (in_range && !in_s.func) ? S_SELF : S_DONE;
          end
        end
        S_SELF: begin
          scan_q  <= (AW+1)'(1);
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // advance the scan; leave once the last boid has been ranked
          if (scan_q == (AW+1)'(bfu_pkg::BOID_COUNT)) begin
            kc_q    <= '0;
            state_q <= S_NBR;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_NBR: begin
          if (kc_q == bfu_pkg::NCNT_W'(N)) begin
            step_q  <= '0;
            state_q <= S_COMB;
          end else begin
            kc_q <= kc_q + 1'b1;
          end
        end
        S_COMB: begin
          step_q <= step_q + 1'b1;
          if (step_q == 2'd3) begin
            state_q <= S_SPEED;
          end
        end
        S_SPEED: state_q <= S_LOG;
        S_LOG: begin
          if (!(|speed_q[32:1])) begin
            state_q <= S_LIMIT;
          end
        end
        S_LIMIT: state_q <= S_EDGE;
        S_EDGE:  state_q <= S_WB;
        S_WB:    state_q <= S_DONE;
        S_DONE: begin
          // hold the result until the output register is free
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          idx_q <= in_s.boid_sel;
          b_q   <= AW'(in_s.boid_sel);
          if (!in_range) begin
            res_x_q <= '0;
            res_y_q <= '0;
          end else begin
            res_x_q <= bfu_pkg::pixel12(in_s.load_x_pos);
            res_y_q <= bfu_pkg::pixel12(in_s.load_y_pos);
          end
        end
      end
      S_SELF: begin
        xp_q <= rd_data.x_pos;
        yp_q <= rd_data.y_pos;
        vx_q <= rd_data.x_vel;
        vy_q <= rd_data.y_vel;
        cx_q <= '0;
        cy_q <= '0;
        rx_q <= '0;
        ry_q <= '0;
        mx_q <= '0;
        my_q <= '0;
      end
      S_NBR: begin
        if (acc_en) begin
          cx_q <= cx_q + bfu_pkg::sar32(rd_data.x_pos, 6'(bfu_pkg::GROUP_SHIFT));
          cy_q <= cy_q + bfu_pkg::sar32(rd_data.y_pos, 6'(bfu_pkg::GROUP_SHIFT));
          mx_q <= mx_q + bfu_pkg::sar32(rd_data.x_vel, 6'(bfu_pkg::GROUP_SHIFT));
          my_q <= my_q + bfu_pkg::sar32(rd_data.y_vel, 6'(bfu_pkg::GROUP_SHIFT));
          if ($signed(nb_dist[ksel]) < $signed({1'b0, repel_q})) begin
            rx_q <= rx_q + (xp_q - rd_data.x_pos);
            ry_q <= ry_q + (yp_q - rd_data.y_pos);
          end
        end
      end
      S_COMB: begin
        case (step_q)
          2'd0: begin
            tx_q <= cx_q - xp_q;
            ty_q <= cy_q - yp_q;
          end
          2'd1: begin
            vx_q <= vx_q + bfu_pkg::sar32(tx_q, {1'b0, coh_shift_q});
            vy_q <= vy_q + bfu_pkg::sar32(ty_q, {1'b0, coh_shift_q});
          end
          2'd2: begin
            vx_q <= vx_q + bfu_pkg::sar32(rx_q, {1'b0, sep_shift_q});
            vy_q <= vy_q + bfu_pkg::sar32(ry_q, {1'b0, sep_shift_q});
          end
          default: begin
            vx_q <= vx_q + bfu_pkg::sar32(mx_q, {1'b0, ali_shift_q});
            vy_q <= vy_q + bfu_pkg::sar32(my_q, {1'b0, ali_shift_q});
          end
        endcase
      end
      S_SPEED: begin
        speed_q <= {1'b0, bfu_pkg::wrap_abs(vx_q)} + {1'b0, bfu_pkg::wrap_abs(vy_q)};
        mag_q   <= '0;
      end
      S_LOG: begin
        // one bit of log2 per cycle
        if (|speed_q[32:1]) begin
          speed_q <= speed_q >> 1;
          mag_q   <= mag_q + 1'b1;
        end
      end
      S_LIMIT: begin
        if (mag_q >= speed_lim_q) begin
          vx_q <= bfu_pkg::sar32(vx_q, lim_shift);
          vy_q <= bfu_pkg::sar32(vy_q, lim_shift);
        end
      end
      S_EDGE: begin
        if ($signed(xp_q) < $signed(bfu_pkg::LOW_BOUND)) begin
          vx_q <= vx_q + {1'b0, push_q};
        end else if ($signed(xp_q) > $signed({1'b0, right_q})) begin
          vx_q <= vx_q - {1'b0, push_q};
        end
        if ($signed(yp_q) < $signed(bfu_pkg::LOW_BOUND)) begin
          vy_q <= vy_q + {1'b0, push_q};
        end else if ($signed(yp_q) > $signed({1'b0, bottom_q})) begin
          vy_q <= vy_q - {1'b0, push_q};
        end
      end
      S_WB: begin
        res_x_q <= bfu_pkg::pixel12(new_x);
        res_y_q <= bfu_pkg::pixel12(new_y);
      end
      S_DONE: begin
        if (slot_free) begin
          out_x_q   <= res_x_q;
          out_y_q   <= res_y_q;
          out_idx_q <= idx_q;
        end
      end
      default: ;
    endcase
  end

  assign out_s.valid     = out_valid_q;
  assign out_s.pixel_x   = out_x_q;
  assign out_s.pixel_y   = out_y_q;
  assign out_s.out_index = out_idx_q;

endmodule

`default_nettype wire

FILE: tb/boid_flock_update_tb.sv
// Testbench for the boid flock update block: drives step and load transfers,
// predicts pixel results with its own flock model and checks every result.
// Depends on bfu_pkg, bfu_if and the boid_flock_update RTL.
`default_nettype none

module boid_flock_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_STEP = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  idx;
  } pixel_t;

  // Scoreboard: flock model plus queue of pending pixel results.
  class flock_scoreboard;
    logic [31:0] xp[bfu_pkg::BOID_COUNT], yp[bfu_pkg::BOID_COUNT];
    logic [31:0] xv[bfu_pkg::BOID_COUNT], yv[bfu_pkg::BOID_COUNT];
    logic [31:0] coh_sh, sep_sh, ali_sh, spd_lim, radius, push, right_lim, bottom_lim;
    pixel_t pending[$];
    int errors;

    function void clear();
      for (int i = 0; i < bfu_pkg::BOID_COUNT; i++) begin
        xp[i] = bfu_pkg::RESET_MARGIN + 32'(i);
        yp[i] = bfu_pkg::RESET_MARGIN + 32'(8 * i);
        xv[i] = bfu_pkg::START_VEL;
        yv[i] = bfu_pkg::START_VEL;
      end
      coh_sh = 6; sep_sh = 4; ali_sh = 2; spd_lim = 22;
      radius = 10485760; push = 1048576; right_lim = 637534208; bottom_lim = 469762048;
      errors = 0;
    endfunction

    function logic [31:0] asr(logic [31:0] v, logic [31:0] s);
      if (s > 31) s = 31;
      return $signed(v) >>> s[4:0];
    endfunction

    function logic [31:0] mag(logic [31:0] v);
      return v[31] ? -v : v;
    endfunction

    function void set_reg(logic [2:0] a, logic [30:0] d);
      case (a)
        bfu_pkg::CFG_COHESION_SHIFT:   coh_sh = 32'(d[4:0]);
        bfu_pkg::CFG_SEPARATION_SHIFT: sep_sh = 32'(d[4:0]);
        bfu_pkg::CFG_ALIGNMENT_SHIFT:  ali_sh = 32'(d[4:0]);
        bfu_pkg::CFG_SPEED_LOG_LIMIT:  spd_lim = 32'(d[5:0]);
        bfu_pkg::CFG_REPEL_RADIUS:     radius = 32'(d);
        bfu_pkg::CFG_EDGE_PUSH_STEP:   push = 32'(d);
        bfu_pkg::CFG_RIGHT_LIMIT:      right_lim = 32'(d);
        bfu_pkg::CFG_BOTTOM_LIMIT:     bottom_lim = 32'(d);
        default: ;
      endcase
    endfunction

    function pixel_t pix(logic [31:0] x, logic [31:0] y, logic [7:0] b);
      pixel_t r;
      r.px = 12'(asr(x, bfu_pkg::FRACTION_BITS));
      r.py = 12'(asr(y, bfu_pkg::FRACTION_BITS));
      r.idx = b;
      return r;
    endfunction

    // note an accepted step or load and queue its pixel result
    function void note_item(logic f, logic [7:0] b, logic [31:0] lx, logic [31:0] ly,
                            logic [31:0] lvx, logic [31:0] lvy);
      int nb[bfu_pkg::NEIGHBOR_COUNT];
      logic signed [31:0] nd[bfu_pkg::NEIGHBOR_COUNT];
      int cnt, cand, tb;
      logic signed [31:0] dc, td;
      logic [31:0] cx, cy, rx, ry, mx, my, vx, vy;
      logic [32:0] speed;
      int m;
      if (b >= bfu_pkg::BOID_COUNT) begin
        pending.push_back('{12'd0, 12'd0, b});
        return;
      end
      if (f == FUNC_LOAD) begin
        xp[b] = lx; yp[b] = ly; xv[b] = lvx; yv[b] = lvy;
        pending.push_back(pix(lx, ly, b));
        return;
      end
      cnt = 0;
      for (int j = 0; j < bfu_pkg::BOID_COUNT; j++) begin
        cand = j;
        dc = mag(xp[b] - xp[j]) + mag(yp[b] - yp[j]);
        for (int k = 0; k < bfu_pkg::NEIGHBOR_COUNT; k++) begin
          if (k == cnt) begin
            nb[k] = cand; nd[k] = dc; cnt++;
            break;
          end
          if (dc < nd[k]) begin
            tb = nb[k]; td = nd[k];
            nb[k] = cand; nd[k] = dc;
            cand = tb; dc = td;
          end
        end
      end
      cx = 0; cy = 0; rx = 0; ry = 0; mx = 0; my = 0;
      for (int k = 0; k < cnt; k++) begin
        cx += asr(xp[nb[k]], bfu_pkg::GROUP_SHIFT);
        cy += asr(yp[nb[k]], bfu_pkg::GROUP_SHIFT);
        if (nd[k] < $signed(radius)) begin
          rx += xp[b] - xp[nb[k]];
          ry += yp[b] - yp[nb[k]];
        end
        mx += asr(xv[nb[k]], bfu_pkg::GROUP_SHIFT);
        my += asr(yv[nb[k]], bfu_pkg::GROUP_SHIFT);
      end
      vx = xv[b] + asr(cx - xp[b], coh_sh) + asr(rx, sep_sh) + asr(mx, ali_sh);
      vy = yv[b] + asr(cy - yp[b], coh_sh) + asr(ry, sep_sh) + asr(my, ali_sh);
      speed = {1'b0, mag(vx)} + {1'b0, mag(vy)};
      m = 0;
      for (int i = 1; i < 33; i++) if (speed[i]) m = i;
      if (m >= spd_lim) begin
        vx = asr(vx, m - spd_lim);
        vy = asr(vy, m - spd_lim);
      end
      if ($signed(xp[b]) < $signed(bfu_pkg::LOW_BOUND)) vx += push;
      else if ($signed(xp[b]) > $signed(right_lim)) vx -= push;
      if ($signed(yp[b]) < $signed(bfu_pkg::LOW_BOUND)) vy += push;
      else if ($signed(yp[b]) > $signed(bottom_lim)) vy -= push;
      xv[b] = vx; yv[b] = vy;
      xp[b] += vx; yp[b] += vy;
      pending.push_back(pix(xp[b], yp[b], b));
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.px !== want.px || got.py !== want.py || got.idx !== want.idx) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected x %0d y %0d idx %0d, got x %0d y %0d idx %0d",
                   $signed(want.px), $signed(want.py), want.idx,
                   $signed(got.px), $signed(got.py), got.idx);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = bfu_pkg::CFG_COHESION_SHIFT;
  logic [30:0] cfg_wdata_i = '0;
  logic no_idle = 1'b0;   // set to suppress idling on both sides
  bit stim_done = 1'b0;

  bfu_in_if in_c();
  bfu_out_if out_c();

  boid_flock_update i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_s(in_c.sink), .out_s(out_c.source)
  );

  flock_scoreboard board = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: drop ready with a chance of about 13 in a hundred, check every transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_c.ready <= 1'b0;
    end else begin
      if (out_c.valid && out_c.ready)
        board.check_result('{out_c.pixel_x, out_c.pixel_y, out_c.out_index});
      out_c.ready <= no_idle || ($urandom_range(99) >= 13);
    end
  end

  // Present one item, hold it until the transfer, then drop valid for a
  // cycle; the block is busy then anyway.
  task automatic send_item(logic f, logic [7:0] b, logic [31:0] lx, logic [31:0] ly,
                           logic [31:0] lvx, logic [31:0] lvy);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_c.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_c.valid <= 1'b1;
    in_c.func <= f;
    in_c.boid_sel <= b;
    in_c.load_x_pos <= lx;
    in_c.load_y_pos <= ly;
    in_c.load_x_vel <= lvx;
    in_c.load_y_vel <= lvy;
    do @(posedge clk_i); while (!in_c.ready);
    board.note_item(f, b, lx, ly, lvx, lvy);
    in_c.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_step(logic [7:0] b);
    send_item(FUNC_STEP, b, '0, '0, '0, '0);
  endtask

  // Wait for every pending result to be checked, then let the clock run on idle.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] a, logic [30:0] d);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= a;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    board.set_reg(a, d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly boids near the play area, sometimes random raw values.
  task automatic random_item();
    logic [7:0] b;
    b = $urandom_range(99) < 80 ? 8'($urandom_range(31)) : 8'($urandom);
    if ($urandom_range(99) < 20) begin
      if ($urandom_range(3) == 0)
        send_item(FUNC_LOAD, b, $urandom, $urandom, $urandom, $urandom);
      else
        send_item(FUNC_LOAD, b, $urandom_range(700000000), $urandom_range(520000000),
                  32'($signed($urandom_range(40000000)) - 20000000),
                  32'($signed($urandom_range(40000000)) - 20000000));
    end else begin
      send_step(b);
    end
  endtask

  task automatic random_settings(bit extreme);
    for (int r = 0; r < 8; r++) begin
      logic [30:0] d;
      if (extreme) d = ($urandom_range(1) != 0) ? '1 : '0;
      else if (r < 3) d = 31'($urandom_range(12));
      else if (r == 3) d = 31'($urandom_range(32));
      else d = 31'($urandom_range(r < 6 ? 30000000 : 700000000));
      if (r == 3 && extreme) d = (d != 0) ? 31'd32 : 31'd0;
      write_reg(3'(r), d);
    end
  endtask

  initial begin
    in_c.valid = 1'b0;
    in_c.func = FUNC_STEP;
    in_c.boid_sel = '0;
    in_c.load_x_pos = '0;
    in_c.load_y_pos = '0;
    in_c.load_x_vel = '0;
    in_c.load_y_vel = '0;
    board.clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset table, loads of extreme values, wrapped distances
    // and limits.
    no_idle <= 1'b1;
    send_step(8'd0);
    send_step(8'd255);
    send_item(FUNC_LOAD, 8'd1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_step(8'd1);
    send_item(FUNC_LOAD, 8'd2, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_step(8'd2);
    send_item(FUNC_LOAD, 8'd3, 32'hffffffff, 32'h0, 32'h0, 32'hffffffff);
    send_step(8'd3);
    send_item(FUNC_LOAD, 8'd4, 32'd700000000, 32'd500000000, 32'd0, 32'd0);
    send_step(8'd4);
    send_step(8'd128);
    drain();
    random_settings(1'b1);
    send_step(8'd5);
    send_step(8'd1);
    send_step(8'd254);
    drain();
    random_settings(1'b1);
    send_step(8'd6);
    send_step(8'd2);
    drain();
    for (int r = 0; r < 8; r++) write_reg(3'(r), '0);
    send_step(8'd7);
    send_step(8'd3);
    drain();
    write_reg(bfu_pkg::CFG_COHESION_SHIFT, 31'd6);
    write_reg(bfu_pkg::CFG_SEPARATION_SHIFT, 31'd4);
    write_reg(bfu_pkg::CFG_ALIGNMENT_SHIFT, 31'd2);
    write_reg(bfu_pkg::CFG_SPEED_LOG_LIMIT, 31'd22);
    write_reg(bfu_pkg::CFG_REPEL_RADIUS, 31'd10485760);
    write_reg(bfu_pkg::CFG_EDGE_PUSH_STEP, 31'd1048576);
    write_reg(bfu_pkg::CFG_RIGHT_LIMIT, 31'd637534208);
    write_reg(bfu_pkg::CFG_BOTTOM_LIMIT, 31'd469762048);

    // Random part in phases; the first runs with no idling at all.
    for (int ph = 0; ph < 6; ph++) begin
      no_idle <= (ph == 0);
      for (int n = 0; n < 190; n++) random_item();
      drain();
      random_settings(ph == 3);
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    drain();
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire
